// ===== rtl/core/chp_pkg.sv =====
// Shared types and constants of the chained hash table.
package chp_pkg;

    localparam int KEY_W   = 31;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;

    localparam int DEF_BUCKETS    = 1021;
    localparam int DEF_POOL_NODES = 1024;

    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // Write enables toward the table memories.
    typedef struct packed {
        logic head_we;
        logic key_we;
        logic data_we;
        logic link_we;
        logic stack_we;
    } mem_we_t;

endpackage

// ===== rtl/core/chp_rem.sv =====
// Remainder unit: key modulo the bucket count by reciprocal multiplication in three stages.
module chp_rem #(
    parameter int BUCKETS = chp_pkg::DEF_BUCKETS,
    parameter int BW      = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [chp_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [BW-1:0]             rem
);
    import chp_pkg::*;

    // (key * RECIP) >> (KEY_W + LW) is the exact quotient for any KEY_W-bit key
    localparam int LW = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam int PW = KEY_W + 32;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (KEY_W + LW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [31:0] RECIP   = RECIP_FULL[31:0];
    localparam logic [16:0] DIVISOR = 17'(BUCKETS);

    logic [KEY_W-1:0] key_reg;
    logic [PW-1:0]    prod_reg;
    logic [KEY_W-1:0] quo;
    logic [KEY_W-1:0] qd_reg;
    logic [BW-1:0]    rem_reg;
    logic [2:0]       stage_reg;
    logic             done_reg;

    assign quo = KEY_W'(prod_reg >> (KEY_W + LW));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= {stage_reg[1:0], start};
            done_reg  <= stage_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
        end
        if (stage_reg[0]) begin
            prod_reg <= PW'(key_reg) * PW'(RECIP);
        end
        if (stage_reg[1]) begin
            qd_reg <= KEY_W'(quo * KEY_W'(DIVISOR));
        end
        if (stage_reg[2]) begin
            rem_reg <= BW'(key_reg - qd_reg);
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/chp_store.sv =====
// Table memories: bucket heads, node key/data/link arrays and the free stack.
module chp_store #(
    parameter int BUCKETS    = chp_pkg::DEF_BUCKETS,
    parameter int POOL_NODES = chp_pkg::DEF_POOL_NODES,
    parameter int BW         = 10,
    parameter int NW         = 10
) (
    input  logic                       aclk,
    input  chp_pkg::mem_we_t           we,
    input  logic [BW-1:0]              head_waddr,
    input  logic [NW:0]                head_wdata,
    input  logic [BW-1:0]              head_raddr,
    output logic [NW:0]                head_rdata,
    input  logic [NW-1:0]              node_waddr,
    input  logic [chp_pkg::KEY_W-1:0]  key_wdata,
    input  logic [chp_pkg::DATA_W-1:0] data_wdata,
    input  logic [NW:0]                link_wdata,
    input  logic [NW-1:0]              node_raddr,
    output logic [chp_pkg::KEY_W-1:0]  key_rdata,
    output logic [chp_pkg::DATA_W-1:0] data_rdata,
    output logic [NW:0]                link_rdata,
    input  logic [NW-1:0]              stack_waddr,
    input  logic [NW-1:0]              stack_wdata,
    input  logic [NW-1:0]              stack_raddr,
    output logic [NW-1:0]              stack_rdata
);
    import chp_pkg::*;

    // head and link entries: {valid, node index}
    logic [NW:0]        head_mem  [BUCKETS];
    logic [KEY_W-1:0]   key_mem   [POOL_NODES];
    logic [DATA_W-1:0]  data_mem  [POOL_NODES];
    logic [NW:0]        link_mem  [POOL_NODES];
    logic [NW-1:0]      stack_mem [POOL_NODES];

    always_ff @(posedge aclk) begin
        if (we.head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rdata <= head_mem[head_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we.key_we) begin
            key_mem[node_waddr] <= key_wdata;
        end
        if (we.data_we) begin
            data_mem[node_waddr] <= data_wdata;
        end
        if (we.link_we) begin
            link_mem[node_waddr] <= link_wdata;
        end
        key_rdata  <= key_mem[node_raddr];
        data_rdata <= data_mem[node_raddr];
        link_rdata <= link_mem[node_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we.stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata <= stack_mem[stack_raddr];
    end

endmodule

// ===== rtl/core/chained_hash_table.sv =====
// Chained hash table top level: operation sequencer, free-pool bookkeeping and result register.
//
// Separate-chaining hash table over a pool of POOL_NODES nodes. Each input beat is a search,
// insert or delete on a 31-bit key and yields exactly one result beat. The bucket index
// (key mod BUCKETS) comes from a three-stage reciprocal-multiply remainder unit, then the bucket
// head is read and the chain is walked one node per cycle through the single read port of the
// node memory. An insert links its node at the head without a walk, an insert on a full pool
// is dropped after the remainder unit, and an unused opcode skips straight to the result.
// A result can be held back by m_tready. After reset the block sweeps the bucket-head memory
// once before s_tready first rises. A result beat waits in an output register, so the next
// item is accepted while it is pending.
module chained_hash_table #(
    parameter int BUCKETS    = chp_pkg::DEF_BUCKETS,
    parameter int POOL_NODES = chp_pkg::DEF_POOL_NODES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[30:0], data_value[62:31], zero[63]
    input  logic [7:0]  s_tuser,   // opcode[1:0], zero[7:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[31:0]
    output logic [7:0]  m_tuser    // found[0], status[2:1], zero[7:3]
);
    import chp_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_DIV  = 6'b000100,
        S_HEAD = 6'b001000,
        S_NODE = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [BW-1:0]       bucket_reg, bucket_next;
    logic [BW-1:0]       clr_reg, clr_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       prev_reg, prev_next;
    logic                prev_ok_reg, prev_ok_next;
    logic [CW-1:0]       steps_reg, steps_next;
    logic [CW-1:0]       free_count_reg, free_count_next;
    logic [CW-1:0]       low_reg, low_next;
    logic                res_found_reg, res_found_next;
    logic [DATA_W-1:0]   res_val_reg, res_val_next;
    logic [ST_W-1:0]     res_st_reg, res_st_next;
    logic                m_tvalid_reg;
    logic                m_found_reg;
    logic [DATA_W-1:0]   m_val_reg;
    logic [ST_W-1:0]     m_st_reg;

    logic                accept, out_load;
    logic                div_start, div_done;
    logic [BW-1:0]       div_rem;
    mem_we_t             we;
    logic [BW-1:0]       head_waddr, head_raddr;
    logic [NW:0]         head_wdata, head_rdata;
    logic [NW-1:0]       node_waddr, node_raddr;
    logic [NW:0]         link_wdata, link_rdata;
    logic [KEY_W-1:0]    key_rdata;
    logic [DATA_W-1:0]   data_rdata;
    logic [NW-1:0]       stack_waddr, stack_wdata, stack_raddr, stack_rdata;
    logic [CW-1:0]       pop_pos;
    logic [NW-1:0]       pop_node;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign div_start = accept && (op_t'(s_tuser[1:0]) != OP_NONE);

    // Free-stack slots below the low-water mark were never pushed, so the
    // node index for them is derived from the position, not read.
    assign pop_pos  = free_count_reg - CW'(1);
    assign pop_node = (pop_pos < low_reg) ? (NW'(POOL_NODES - 1) - pop_pos[NW-1:0])
                                          : stack_rdata;

    chp_rem #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .key     (s_tdata[KEY_W-1:0]),
        .done    (div_done),
        .rem     (div_rem)
    );

    chp_store #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES),
        .BW         (BW),
        .NW         (NW)
    ) u_store (
        .aclk        (aclk),
        .we          (we),
        .head_waddr  (head_waddr),
        .head_wdata  (head_wdata),
        .head_raddr  (head_raddr),
        .head_rdata  (head_rdata),
        .node_waddr  (node_waddr),
        .key_wdata   (key_reg),
        .data_wdata  (val_reg),
        .link_wdata  (link_wdata),
        .node_raddr  (node_raddr),
        .key_rdata   (key_rdata),
        .data_rdata  (data_rdata),
        .link_rdata  (link_rdata),
        .stack_waddr (stack_waddr),
        .stack_wdata (stack_wdata),
        .stack_raddr (stack_raddr),
        .stack_rdata (stack_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        bucket_next     = bucket_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_ok_next    = prev_ok_reg;
        steps_next      = steps_reg;
        free_count_next = free_count_reg;
        low_next        = low_reg;
        res_found_next  = res_found_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        we              = '0;
        head_waddr      = bucket_reg;
        head_wdata      = '0;
        head_raddr      = div_rem;
        node_waddr      = pop_node;
        node_raddr      = head_rdata[NW-1:0];
        link_wdata      = head_rdata;
        stack_waddr     = free_count_reg[NW-1:0];
        stack_wdata     = cur_reg;
        stack_raddr     = pop_pos[NW-1:0];

        case (state_reg)
            S_CLR: begin
                we.head_we = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                res_found_next = 1'b0;
                res_val_next   = '0;
                res_st_next    = ST_OK;
                if (accept) begin
                    state_next = (op_t'(s_tuser[1:0]) == OP_NONE) ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    bucket_next = div_rem;
                    if (op_reg == OP_INSERT && free_count_reg == '0) begin
                        res_st_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                if (op_reg == OP_INSERT) begin
                    we.key_we  = 1'b1;
                    we.data_we = 1'b1;
                    we.link_we = 1'b1;
                    we.head_we = 1'b1;
                    head_wdata = {1'b1, pop_node};
                    free_count_next = pop_pos;
                    if (pop_pos < low_reg) begin
                        low_next = pop_pos;
                    end
                    state_next = S_DONE;
                end else if (!head_rdata[NW]) begin
                    res_st_next = ST_MISS;
                    state_next  = S_DONE;
                end else begin
                    cur_next     = head_rdata[NW-1:0];
                    prev_ok_next = 1'b0;
                    steps_next   = '0;
                    state_next   = S_NODE;
                end
            end
            S_NODE: begin
                node_raddr = link_rdata[NW-1:0];
                if (key_rdata == key_reg) begin
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                    if (op_reg == OP_SEARCH) begin
                        res_val_next = data_rdata;
                    end else begin
                        // unlink: bypass the matched node from its predecessor
                        link_wdata = link_rdata;
                        head_wdata = link_rdata;
                        node_waddr = prev_reg;
                        if (prev_ok_reg) begin
                            we.link_we = 1'b1;
                        end else begin
                            we.head_we = 1'b1;
                        end
                        if (free_count_reg < CW'(POOL_NODES)) begin
                            we.stack_we     = 1'b1;
                            free_count_next = free_count_reg + CW'(1);
                        end
                    end
                end else if (!link_rdata[NW] || steps_reg == CW'(POOL_NODES - 1)) begin
                    res_st_next = ST_MISS;
                    state_next  = S_DONE;
                end else begin
                    prev_next    = cur_reg;
                    prev_ok_next = 1'b1;
                    cur_next     = link_rdata[NW-1:0];
                    steps_next   = steps_reg + CW'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            free_count_reg <= CW'(POOL_NODES);
            low_reg        <= CW'(POOL_NODES);
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            low_reg        <= low_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_tuser[1:0]);
            key_reg <= s_tdata[KEY_W-1:0];
            val_reg <= s_tdata[KEY_W+DATA_W-1:KEY_W];
        end
        bucket_reg    <= bucket_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_ok_reg   <= prev_ok_next;
        steps_reg     <= steps_next;
        res_found_reg <= res_found_next;
        res_val_reg   <= res_val_next;
        res_st_reg    <= res_st_next;
        if (out_load) begin
            m_found_reg <= res_found_reg;
            m_val_reg   <= res_val_reg;
            m_st_reg    <= res_st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_val_reg;
    assign m_tuser  = {5'b0, m_st_reg, m_found_reg};

    a_low_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= free_count_reg)
        else $error("free-stack low-water mark above free count");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= CW'(POOL_NODES))
        else $error("free count exceeds pool size");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK)
        else $error("found result with non-ok status");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("read value nonzero without a match");

endmodule

// ===== verif/chained_hash_table_tb.sv =====
// Self-checking testbench for the chained hash table: stream stimulus, table predictor, result check.
module chained_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import chp_pkg::*;

    localparam int NB = DEF_BUCKETS;
    localparam int NP = DEF_POOL_NODES;
    localparam int NO_NODE = -1;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] rd_val;
        logic [ST_W-1:0]   status;
    } lookup_res_t;

    // Table predictor plus the store of expected lookup results.
    class table_board;
        int heads[NB];
        logic [KEY_W-1:0] nkey[NP];
        logic [DATA_W-1:0] ndata[NP];
        int nlink[NP];
        int free_stk[NP];
        int free_cnt;
        lookup_res_t pending[$];
        int errors;

        function new();
            for (int i = 0; i < NB; i++) heads[i] = NO_NODE;
            for (int i = 0; i < NP; i++) begin
                nlink[i] = NO_NODE;
                free_stk[i] = NP - 1 - i;
            end
            free_cnt = NP;
            errors = 0;
        endfunction

        function int live_nodes();
            return NP - free_cnt;
        endfunction

        function void note_op(op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
            lookup_res_t r;
            int b, cur, prv, steps, n;
            r = '0;
            b = int'(k % NB);
            if (op == OP_SEARCH || op == OP_DELETE) begin
                cur = heads[b];
                prv = NO_NODE;
                n = NO_NODE;
                steps = 0;
                while (cur != NO_NODE && steps < NP) begin
                    if (nkey[cur] == k) begin
                        n = cur;
                        break;
                    end
                    prv = cur;
                    cur = nlink[cur];
                    steps++;
                end
                if (n == NO_NODE) r.status = ST_MISS;
                else begin
                    r.found = 1'b1;
                    if (op == OP_SEARCH) r.rd_val = ndata[n];
                    else begin
                        if (prv == NO_NODE) heads[b] = nlink[n];
                        else nlink[prv] = nlink[n];
                        free_stk[free_cnt] = n;
                        free_cnt++;
                    end
                end
            end else if (op == OP_INSERT) begin
                if (free_cnt == 0) r.status = ST_FULL;
                else begin
                    free_cnt--;
                    n = free_stk[free_cnt];
                    nkey[n] = k;
                    ndata[n] = v;
                    nlink[n] = heads[b];
                    heads[b] = n;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_beat(logic [31:0] d, logic [7:0] u);
            lookup_res_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: data %h user %h", d, u);
                return;
            end
            e = pending.pop_front();
            if (u[0] !== e.found || d !== e.rd_val || u[2:1] !== e.status || u[7:3] !== 5'd0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp found %0b val %h st %0d, got found %0b val %h st %0d",
                             e.found, e.rd_val, e.status, u[0], d, u[2:1]);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic [7:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [7:0] m_tuser;

    table_board board = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_sink = 1'b0;
    longint cycles = 0;
    logic [KEY_W-1:0] key_pool[16];

    chained_hash_table dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check on handshake, then pick next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser);
        m_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
    end

    // tvalid stays up after an accept so the next beat can follow at once;
    // it drops only in idle cycles and in drain.
    task automatic send_op(op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, v, k};
        s_tuser <= {6'd0, op};
        do @(posedge aclk); while (!s_tready);
        board.note_op(op, k, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Random op mix; small key pool so chains and duplicates form.
    task automatic random_ops(int n, int ins_w);
        op_t op;
        logic [KEY_W-1:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 2) op = OP_NONE;
            else if (r < ins_w) op = OP_INSERT;
            else if (r < (ins_w + 100) / 2) op = OP_SEARCH;
            else op = OP_DELETE;
            if ($urandom_range(9) < 7) begin
                k = key_pool[$urandom_range(15)];
                if ($urandom_range(3) == 0) k = KEY_W'(k + NB * $urandom_range(3));
            end else k = KEY_W'($urandom());
            send_op(op, k, $urandom());
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) key_pool[i] = KEY_W'($urandom());
        key_pool[0] = '0;
        key_pool[1] = KEY_W'(NB);
        key_pool[2] = 31'h7fff_ffff;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: misses, inserts, duplicates, chain collisions, deletes, unused opcode.
        send_op(OP_SEARCH, '0, '0);
        send_op(OP_DELETE, '0, '0);
        send_op(OP_INSERT, '0, 32'h8000_0000);
        send_op(OP_INSERT, KEY_W'(NB), 32'h7fff_ffff);
        send_op(OP_INSERT, KEY_W'(2 * NB), 32'hffff_ffff);
        send_op(OP_INSERT, 31'h7fff_ffff, 32'h5555_aaaa);
        send_op(OP_INSERT, '0, 32'h1234_5678);
        send_op(OP_SEARCH, '0, '0);
        send_op(OP_SEARCH, KEY_W'(NB), '0);
        send_op(OP_SEARCH, 31'h7fff_ffff, '0);
        send_op(OP_DELETE, KEY_W'(NB), '0);
        send_op(OP_SEARCH, KEY_W'(NB), '0);
        send_op(OP_DELETE, '0, '0);
        send_op(OP_SEARCH, '0, 32'hffff_ffff);
        send_op(OP_DELETE, KEY_W'(2 * NB), '0);
        send_op(OP_NONE, 31'h7fff_ffff, 32'hffff_ffff);
        send_op(OP_SEARCH, KEY_W'(3 * NB), '0);
        send_op(OP_DELETE, '0, '0);
        send_op(OP_DELETE, '0, '0);

        // Phase: no idling.
        random_ops(150, 40);
        // Sink holds off while source keeps pushing.
        fork
            begin
                hold_sink = 1'b1;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            random_ops(40, 40);
        join
        src_idle_pct = 88;
        random_ops(120, 40);
        src_idle_pct = 0;
        sink_stall_pct = 88;
        random_ops(120, 40);
        src_idle_pct = 10;
        sink_stall_pct = 10;
        random_ops(150, 40);
        src_idle_pct = 0;
        sink_stall_pct = 0;

        // Fill the pool to the brim, then hit full drops, then run a mix heavy on inserts and one heavy on deletes.
        while (board.live_nodes() < NP) send_op(OP_INSERT, KEY_W'($urandom()), $urandom());
        for (int i = 0; i < 8; i++) send_op(OP_INSERT, key_pool[i], $urandom());
        random_ops(150, 60);
        sink_stall_pct = 30;
        random_ops(200, 20);

        drain();
        if (board.errors == 0 && board.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
